// ===== src/rhbp_pkg.sv =====
// Shared types, byte codes and header-name and value tables for the header block parser.
package rhbp_pkg;

    localparam int LENGTH_BITS_DEF = 32;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VCR   = 8'h0D;

    localparam logic [3:0] NAME_LEN_CHARS = 4'd14;
    localparam logic [3:0] NAME_TYP_CHARS = 4'd12;
    localparam logic [3:0] NAME_POS_MAX   = 4'd15;
    localparam logic [2:0] VAL_A_CHARS    = 3'd5;
    localparam logic [2:0] VAL_B_CHARS    = 3'd4;
    localparam logic [2:0] VAL_POS_MAX    = 3'd7;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0,
        ERR_PARSE  = 3'd1,
        ERR_HEADER = 3'd2,
        ERR_TYPE   = 3'd3,
        ERR_LENGTH = 3'd4
    } t_err;

    typedef enum logic [2:0] {
        LP_NAME  = 3'b001,
        LP_SKIP  = 3'b010,
        LP_VALUE = 3'b100
    } t_line_phase;

    typedef enum logic [3:0] {
        NP_LEAD   = 4'b0001,
        NP_SIGN   = 4'b0010,
        NP_DIGITS = 4'b0100,
        NP_STOP   = 4'b1000
    } t_num_phase;

    typedef struct packed {
        t_num_phase phase;
        logic       negative;
        logic       overflow;
    } t_num_flags;

    localparam t_num_flags NUM_FLAGS_CLR = '{phase: NP_LEAD, negative: 1'b0, overflow: 1'b0};

    function automatic logic [7:0] f_len_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "L";
            4'd9:    c = "e";
            4'd10:   c = "n";
            4'd11:   c = "g";
            4'd12:   c = "t";
            4'd13:   c = "h";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] f_typ_char(input logic [3:0] pos);
        logic [7:0] c;
        case (pos)
            4'd0:    c = "C";
            4'd1:    c = "o";
            4'd2:    c = "n";
            4'd3:    c = "t";
            4'd4:    c = "e";
            4'd5:    c = "n";
            4'd6:    c = "t";
            4'd7:    c = "-";
            4'd8:    c = "T";
            4'd9:    c = "y";
            4'd10:   c = "p";
            4'd11:   c = "e";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] f_val_a_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = "u";
            3'd1:    c = "t";
            3'd2:    c = "f";
            3'd3:    c = "-";
            3'd4:    c = "8";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] f_val_b_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = "u";
            3'd1:    c = "t";
            3'd2:    c = "f";
            3'd3:    c = "8";
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // bit0 Content-Length, bit1 Content-Type
    function automatic logic [1:0] f_name_hit(input logic [3:0] pos, input logic [7:0] b);
        logic [1:0] h;
        h[0] = (pos < NAME_LEN_CHARS) && (b == f_len_char(pos));
        h[1] = (pos < NAME_TYP_CHARS) && (b == f_typ_char(pos));
        return h;
    endfunction

    // bit0 "utf-8", bit1 "utf8"
    function automatic logic [1:0] f_val_hit(input logic [2:0] pos, input logic [7:0] b);
        logic [1:0] h;
        h[0] = (pos < VAL_A_CHARS) && (b == f_val_a_char(pos));
        h[1] = (pos < VAL_B_CHARS) && (b == f_val_b_char(pos));
        return h;
    endfunction

endpackage

// ===== src/rhbp_number.sv =====
// Decimal length parser step: one value byte, range check and signed result.
module rhbp_number
    import rhbp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic [7:0]             i_byte,
    input  t_num_flags             i_flags,
    input  logic [LENGTH_BITS-1:0] i_acc,
    output t_num_flags             o_flags,
    output logic [LENGTH_BITS-1:0] o_acc,
    output logic                   o_bad,
    output logic [LENGTH_BITS-1:0] o_value
);

    localparam int PW = LENGTH_BITS + 4;

    logic          w_digit;
    logic          w_space;
    logic          w_take;
    logic [PW-1:0] w_ext;
    logic [PW-1:0] w_prod;
    logic [PW-1:0] w_lim_ext;
    logic [LENGTH_BITS-1:0] w_lim;

    assign w_digit   = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign w_space   = (i_byte == CH_SPACE) || ((i_byte >= CH_TAB) && (i_byte <= CH_VCR));
    assign w_ext     = PW'(i_acc);
    assign w_prod    = (w_ext << 3) + (w_ext << 1) + PW'(i_byte - CH_ZERO);
    assign w_lim_ext = PW'(1) << (LENGTH_BITS - 1);
    assign w_lim     = LENGTH_BITS'(1) << (LENGTH_BITS - 1);

    always_comb begin
        o_flags = i_flags;
        o_acc   = i_acc;
        w_take  = 1'b0;
        case (i_flags.phase)
            NP_LEAD: begin
                if (w_space) begin
                    w_take = 1'b0;
                end else if ((i_byte == CH_PLUS) || (i_byte == CH_MINUS)) begin
                    o_flags.negative = (i_byte == CH_MINUS);
                    o_flags.phase    = NP_SIGN;
                end else if (!w_digit) begin
                    o_flags.overflow = 1'b1;
                    o_flags.phase    = NP_STOP;
                end else begin
                    o_flags.phase = NP_DIGITS;
                    w_take        = 1'b1;
                end
            end
            NP_SIGN: begin
                if (!w_digit) begin
                    o_flags.overflow = 1'b1;
                    o_flags.phase    = NP_STOP;
                end else begin
                    o_flags.phase = NP_DIGITS;
                    w_take        = 1'b1;
                end
            end
            NP_DIGITS: begin
                if (!w_digit) begin
                    o_flags.phase = NP_STOP;
                end else begin
                    w_take = 1'b1;
                end
            end
            default: begin
                w_take = 1'b0;
            end
        endcase
        if (w_take && !i_flags.overflow) begin
            if (w_prod > w_lim_ext) begin
                o_flags.overflow = 1'b1;
            end else begin
                o_acc = w_prod[LENGTH_BITS-1:0];
            end
        end
    end

    assign o_bad = i_flags.overflow
                || (i_flags.phase == NP_LEAD) || (i_flags.phase == NP_SIGN)
                || (i_flags.negative ? (i_acc > w_lim) : (i_acc > (w_lim - 1'b1)));
    assign o_value = i_flags.negative ? (LENGTH_BITS'(0) - i_acc) : i_acc;

endmodule

// ===== src/rpc_header_block_parser_core.sv =====
// Top level of the header block parser: line framing, name/value match, result register.
//
//  channel | valid       | ready       | payload
//  --------+-------------+-------------+----------------------------------------------
//  in      | i_in_valid  | o_in_ready  | i_in_byte, i_stream_end
//  out     | o_out_valid | i_out_ready | o_content_length, o_type_given, o_error_code
//
// One word per cycle; each word updates the parser state in the cycle it is accepted.
// A result appears in the output register in the cycle after the LF of the empty line
// or after a stream-end word, and the input keeps flowing while it drains.
// Input stalls only while an untaken result sits in the output register.
// Synchronous active-low reset clears the parser state and the output valid.
module rpc_header_block_parser_core
    import rhbp_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [7:0]         i_in_byte,
    input  logic               i_stream_end,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_content_length,
    output logic               o_type_given,
    output logic [2:0]         o_error_code
);

    logic                          r_after_cr,   n_after_cr;
    t_line_phase                   r_line_phase, n_line_phase;
    logic                          r_line_empty, n_line_empty;
    logic [3:0]                    r_name_pos,   n_name_pos;
    logic [1:0]                    r_name_flags, n_name_flags;
    t_num_flags                    r_num_flags,  n_num_flags;
    logic [LENGTH_BITS-1:0]        r_num_acc,    n_num_acc;
    logic [2:0]                    r_val_pos,    n_val_pos;
    logic [1:0]                    r_val_flags,  n_val_flags;
    t_err                          r_first_err,  n_first_err;
    logic signed [LENGTH_BITS-1:0] r_len_held,   n_len_held;
    logic                          r_type_held,  n_type_held;
    logic                          r_out_valid,  n_out_valid;
    logic signed [31:0]            r_out_len,    n_out_len;
    logic                          r_out_type,   n_out_type;
    t_err                          r_out_err,    n_out_err;

    logic                   w_fire;
    logic                   w_emit;
    t_num_flags             w_num_flags;
    logic [LENGTH_BITS-1:0] w_num_acc;
    logic                   w_num_bad;
    logic [LENGTH_BITS-1:0] w_num_value;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_fire     = i_in_valid && o_in_ready;

    rhbp_number #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_number (
        .i_byte  (i_in_byte),
        .i_flags (r_num_flags),
        .i_acc   (r_num_acc),
        .o_flags (w_num_flags),
        .o_acc   (w_num_acc),
        .o_bad   (w_num_bad),
        .o_value (w_num_value)
    );

    always_comb begin
        n_after_cr   = r_after_cr;
        n_line_phase = r_line_phase;
        n_line_empty = r_line_empty;
        n_name_pos   = r_name_pos;
        n_name_flags = r_name_flags;
        n_num_flags  = r_num_flags;
        n_num_acc    = r_num_acc;
        n_val_pos    = r_val_pos;
        n_val_flags  = r_val_flags;
        n_first_err  = r_first_err;
        n_len_held   = r_len_held;
        n_type_held  = r_type_held;
        w_emit       = 1'b0;
        n_out_len    = r_out_len;
        n_out_type   = r_out_type;
        n_out_err    = r_out_err;

        if (w_fire) begin
            if (i_stream_end) begin
                w_emit       = 1'b1;
                n_out_len    = '0;
                n_out_type   = 1'b0;
                n_out_err    = ERR_PARSE;
                n_first_err  = ERR_NONE;
                n_len_held   = '0;
                n_type_held  = 1'b0;
                n_after_cr   = 1'b0;
                n_line_phase = LP_NAME;
                n_line_empty = 1'b1;
                n_name_pos   = '0;
                n_name_flags = 2'b11;
                n_num_flags  = NUM_FLAGS_CLR;
                n_num_acc    = '0;
                n_val_pos    = '0;
                n_val_flags  = 2'b11;
            end else if (r_after_cr) begin
                if (i_in_byte == CH_LF) begin
                    if (r_line_empty) begin
                        w_emit      = 1'b1;
                        n_out_len   = 32'(r_len_held);
                        n_out_type  = r_type_held;
                        n_out_err   = r_first_err;
                        n_first_err = ERR_NONE;
                        n_len_held  = '0;
                        n_type_held = 1'b0;
                    end else if (r_first_err == ERR_NONE) begin
                        if (r_line_phase != LP_VALUE) begin
                            n_first_err = ERR_PARSE;
                        end else if (r_name_flags[0] && (r_name_pos == NAME_LEN_CHARS)) begin
                            if (w_num_bad) begin
                                n_first_err = ERR_LENGTH;
                            end else begin
                                n_len_held = w_num_value;
                            end
                        end else if (r_name_flags[1] && (r_name_pos == NAME_TYP_CHARS)) begin
                            if ((r_val_flags[0] && (r_val_pos == VAL_A_CHARS))
                                    || (r_val_flags[1] && (r_val_pos == VAL_B_CHARS))) begin
                                n_type_held = 1'b1;
                            end else begin
                                n_first_err = ERR_TYPE;
                            end
                        end else begin
                            n_first_err = ERR_HEADER;
                        end
                    end
                    n_after_cr   = 1'b0;
                    n_line_phase = LP_NAME;
                    n_line_empty = 1'b1;
                    n_name_pos   = '0;
                    n_name_flags = 2'b11;
                    n_num_flags  = NUM_FLAGS_CLR;
                    n_num_acc    = '0;
                    n_val_pos    = '0;
                    n_val_flags  = 2'b11;
                end
            end else if (i_in_byte == CH_CR) begin
                n_after_cr = 1'b1;
            end else begin
                n_line_empty = 1'b0;
                case (r_line_phase)
                    LP_NAME: begin
                        if (i_in_byte == CH_COLON) begin
                            n_line_phase = LP_SKIP;
                        end else begin
                            n_name_flags = r_name_flags & f_name_hit(r_name_pos, i_in_byte);
                            if (r_name_pos < NAME_POS_MAX) begin
                                n_name_pos = r_name_pos + 4'd1;
                            end
                        end
                    end
                    LP_SKIP: begin
                        if (i_in_byte == CH_SPACE) begin
                            n_line_phase = LP_VALUE;
                        end
                    end
                    LP_VALUE: begin
                        n_val_flags = r_val_flags & f_val_hit(r_val_pos, i_in_byte);
                        if (r_val_pos < VAL_POS_MAX) begin
                            n_val_pos = r_val_pos + 3'd1;
                        end
                        n_num_flags = w_num_flags;
                        n_num_acc   = w_num_acc;
                    end
                    default: begin
                        n_line_phase = LP_NAME;
                    end
                endcase
            end
        end

        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_cr   <= 1'b0;
            r_line_phase <= LP_NAME;
            r_line_empty <= 1'b1;
            r_name_pos   <= '0;
            r_name_flags <= 2'b11;
            r_num_flags  <= NUM_FLAGS_CLR;
            r_num_acc    <= '0;
            r_val_pos    <= '0;
            r_val_flags  <= 2'b11;
            r_first_err  <= ERR_NONE;
            r_len_held   <= '0;
            r_type_held  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_after_cr   <= n_after_cr;
            r_line_phase <= n_line_phase;
            r_line_empty <= n_line_empty;
            r_name_pos   <= n_name_pos;
            r_name_flags <= n_name_flags;
            r_num_flags  <= n_num_flags;
            r_num_acc    <= n_num_acc;
            r_val_pos    <= n_val_pos;
            r_val_flags  <= n_val_flags;
            r_first_err  <= n_first_err;
            r_len_held   <= n_len_held;
            r_type_held  <= n_type_held;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_len  <= n_out_len;
        r_out_type <= n_out_type;
        r_out_err  <= n_out_err;
    end

    assign o_out_valid      = r_out_valid;
    assign o_content_length = r_out_len;
    assign o_type_given     = r_out_type;
    assign o_error_code     = r_out_err;

endmodule

// ===== tb/rpc_header_block_parser_core_tb.sv =====
// Self-checking testbench for the header block parser: directed rows, random header blocks.
module rpc_header_block_parser_core_tb;
    import rhbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [31:0] len;
        logic               typ;
        t_err               err;
    } t_hdr_result;

    localparam logic [63:0] LEN_LIMIT = 64'd1 << (LENGTH_BITS_DEF - 1);

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [7:0]         i_in_byte = 8'd0;
    logic               i_stream_end = 1'b0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_content_length;
    logic               o_type_given;
    logic [2:0]         o_error_code;

    rpc_header_block_parser_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_in_byte        (i_in_byte),
        .i_stream_end     (i_stream_end),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_content_length (o_content_length),
        .o_type_given     (o_type_given),
        .o_error_code     (o_error_code)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    string len_name  = "Content-Length";
    string typ_name  = "Content-Type";
    string utf_dash  = "utf-8";
    string utf_plain = "utf8";

    // shadow parser state
    logic        cr_seen;
    t_line_phase seg;
    logic        line_blank;
    logic [3:0]  nlen;
    logic [1:0]  name_hits;
    t_num_phase  num_st;
    logic [63:0] mag;
    logic        neg;
    logic        bad_num;
    logic [2:0]  vlen;
    logic [1:0]  val_hits;
    t_err        err_hold;
    logic [31:0] len_hold;
    logic        typ_hold;

    t_hdr_result header_results_due[$];
    int          mismatches = 0;
    int          words_sent = 0;
    int          snd_idle_pct = 0;
    int          rcv_idle_pct = 0;
    logic        word_typed = 1'b0;
    t_hdr_result word_typed_res = '0;
    logic [7:0]  blk[$];

    string       row_text[$];
    bit          row_end[$];
    bit          row_typed[$];
    t_hdr_result row_exp[$];

    function automatic void clear_line();
        cr_seen    = 1'b0;
        seg        = LP_NAME;
        line_blank = 1'b1;
        nlen       = '0;
        name_hits  = 2'b11;
        num_st     = NP_LEAD;
        mag        = '0;
        neg        = 1'b0;
        bad_num    = 1'b0;
        vlen       = '0;
        val_hits   = 2'b11;
    endfunction

    function automatic void clear_block();
        clear_line();
        err_hold = ERR_NONE;
        len_hold = '0;
        typ_hold = 1'b0;
    endfunction

    function automatic void feed_number(input logic [7:0] b);
        logic        digit;
        logic [63:0] d;
        digit = (b >= CH_ZERO) && (b <= CH_NINE);
        case (num_st)
            NP_LEAD: begin
                if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
                    return;
                if (b == CH_PLUS || b == CH_MINUS) begin
                    neg    = (b == CH_MINUS);
                    num_st = NP_SIGN;
                    return;
                end
                if (!digit) begin
                    bad_num = 1'b1;
                    num_st  = NP_STOP;
                    return;
                end
                num_st = NP_DIGITS;
            end
            NP_SIGN: begin
                if (!digit) begin
                    bad_num = 1'b1;
                    num_st  = NP_STOP;
                    return;
                end
                num_st = NP_DIGITS;
            end
            NP_DIGITS: begin
                if (!digit) begin
                    num_st = NP_STOP;
                    return;
                end
            end
            default: return;
        endcase
        if (!bad_num) begin
            d = 64'(b - CH_ZERO);
            if (mag > (LEN_LIMIT - d) / 10)
                bad_num = 1'b1;
            else
                mag = mag * 10 + d;
        end
    endfunction

    function automatic void feed_byte(input logic [7:0] b);
        case (seg)
            LP_NAME: begin
                if (b == CH_COLON) begin
                    seg = LP_SKIP;
                    return;
                end
                if (!(nlen < NAME_LEN_CHARS && b == len_name[nlen])) name_hits[0] = 1'b0;
                if (!(nlen < NAME_TYP_CHARS && b == typ_name[nlen])) name_hits[1] = 1'b0;
                if (nlen < NAME_POS_MAX) nlen++;
            end
            LP_SKIP: begin
                if (b == CH_SPACE) seg = LP_VALUE;
            end
            default: begin
                if (!(vlen < VAL_A_CHARS && b == utf_dash[vlen])) val_hits[0] = 1'b0;
                if (!(vlen < VAL_B_CHARS && b == utf_plain[vlen])) val_hits[1] = 1'b0;
                if (vlen < VAL_POS_MAX) vlen++;
                feed_number(b);
            end
        endcase
    endfunction

    function automatic void finish_line();
        logic        bad;
        logic [63:0] negated;
        if (err_hold != ERR_NONE) return;
        if (seg != LP_VALUE) begin
            err_hold = ERR_PARSE;
            return;
        end
        if (name_hits[0] && nlen == NAME_LEN_CHARS) begin
            bad = bad_num || num_st == NP_LEAD || num_st == NP_SIGN;
            if (!bad) bad = neg ? (mag > LEN_LIMIT) : (mag > LEN_LIMIT - 1);
            if (bad) begin
                err_hold = ERR_LENGTH;
                return;
            end
            negated  = 64'd0 - mag;
            len_hold = neg ? negated[31:0] : mag[31:0];
        end else if (name_hits[1] && nlen == NAME_TYP_CHARS) begin
            if ((val_hits[0] && vlen == VAL_A_CHARS) || (val_hits[1] && vlen == VAL_B_CHARS))
                typ_hold = 1'b1;
            else
                err_hold = ERR_TYPE;
        end else begin
            err_hold = ERR_HEADER;
        end
    endfunction

    function automatic void predict_header_result(input logic [7:0] b, input logic ends,
                                                  output logic got, output t_hdr_result r);
        got = 1'b0;
        r   = '0;
        if (ends) begin
            r.err = ERR_PARSE;
            got   = 1'b1;
            clear_block();
            return;
        end
        if (cr_seen) begin
            if (b == CH_LF) begin
                if (line_blank) begin
                    r.len = len_hold;
                    r.typ = typ_hold;
                    r.err = err_hold;
                    got   = 1'b1;
                    clear_block();
                    return;
                end
                finish_line();
                clear_line();
            end
            return;
        end
        if (b == CH_CR) begin
            cr_seen = 1'b1;
            return;
        end
        line_blank = 1'b0;
        feed_byte(b);
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin : monitor
        logic        got;
        t_hdr_result r;
        t_hdr_result due;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                predict_header_result(i_in_byte, i_stream_end, got, r);
                if (got) begin
                    if (word_typed) r = word_typed_res;
                    header_results_due.insert(header_results_due.size(), r);
                end
            end
            if (o_out_valid && i_out_ready) begin
                if (header_results_due.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    due = header_results_due.pop_front();
                    if (o_content_length !== due.len || o_type_given !== due.typ ||
                        o_error_code !== due.err)
                        report_mismatch($sformatf(
                            "length %0d/%0d type %0b/%0b code %0d/%0d (got/exp)",
                            o_content_length, due.len, o_type_given, due.typ,
                            o_error_code, due.err));
                end
            end
        end
    end

    always @(negedge i_clk)
        i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);

    task automatic drive_word(input logic [7:0] b, input logic ends, input logic typed,
                              input t_hdr_result tres);
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_in_byte      <= b;
        i_stream_end   <= ends;
        word_typed     <= typed;
        word_typed_res <= tres;
        do @(posedge i_clk); while (!o_in_ready);
        words_sent++;
    endtask

    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        word_typed <= 1'b0;
        while (header_results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic add_row(input string text, input bit ends, input bit typed,
                           input logic signed [31:0] len, input bit typ, input t_err err);
        t_hdr_result r;
        r.len = len;
        r.typ = typ;
        r.err = err;
        row_text.insert(row_text.size(), text);
        row_end.insert(row_end.size(), ends);
        row_typed.insert(row_typed.size(), typed);
        row_exp.insert(row_exp.size(), r);
    endtask

    task automatic put_byte(input logic [7:0] b);
        blk.insert(blk.size(), b);
    endtask

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++) put_byte(s[k]);
    endtask

    task automatic put_crlf();
        put_byte(CH_CR);
        put_byte(CH_LF);
    endtask

    task automatic put_name(input string s);
        int bad;
        bad = ($urandom_range(7) == 0) ? $urandom_range(s.len()) : -1;
        for (int k = 0; k < s.len(); k++)
            put_byte((k == bad) ? 8'($urandom_range(255)) : s[k]);
        if (bad == s.len()) put_byte(8'($urandom_range(255)));
    endtask

    task automatic put_length_value();
        logic [63:0] magv;
        logic        negv;
        int          kind;
        kind = $urandom_range(9);
        negv = ($urandom_range(3) == 0);
        case (kind)
            0, 1, 2, 3: magv = 64'($urandom_range(999));
            4, 5:       magv = 64'($urandom);
            6:          magv = 64'd2147483647 + 64'($urandom_range(2));
            7:          magv = {$urandom, $urandom};
            default:    magv = '0;
        endcase
        if ($urandom_range(4) == 0)
            repeat ($urandom_range(1, 3))
                put_byte($urandom_range(1) ? CH_SPACE : 8'(CH_TAB + $urandom_range(3)));
        if (kind >= 8) begin
            if (negv)
                put_text("-");
            else if (kind == 8)
                put_text("abc");
            else
                put_text("+z");
            return;
        end
        if (negv)
            put_byte(CH_MINUS);
        else if ($urandom_range(5) == 0)
            put_byte(CH_PLUS);
        if ($urandom_range(7) == 0) put_text("00");
        put_text($sformatf("%0d", magv));
        if ($urandom_range(5) == 0) put_text(" ;x");
    endtask

    task automatic put_type_value();
        case ($urandom_range(9))
            0, 1, 2, 3: put_text("utf-8");
            4, 5:       put_text("utf8");
            6:          put_text("utf-16");
            7:          put_text("UTF-8");
            8:          put_text("utf88");
            default:    repeat ($urandom_range(6)) put_byte(8'($urandom_range(33, 126)));
        endcase
    endtask

    task automatic put_header_line();
        int r;
        int sep;
        r = $urandom_range(99);
        if (r < 10) begin
            repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(255)));
            put_crlf();
            return;
        end
        if (r < 55)
            put_name(len_name);
        else if (r < 85)
            put_name(typ_name);
        else
            case ($urandom_range(2))
                0:       put_name("Host");
                1:       put_name("Content-Lengthy");
                default: put_name("Content-Typ");
            endcase
        sep = $urandom_range(99);
        if (sep < 80) begin
            put_byte(CH_COLON);
            put_byte(CH_SPACE);
        end else if (sep < 87) begin
            put_byte(CH_COLON);
            repeat ($urandom_range(1, 2)) put_byte(8'($urandom_range(33, 126)));
            put_byte(CH_SPACE);
        end else if (sep < 93) begin
            put_byte(CH_COLON);
        end else begin
            put_byte(CH_SPACE);
        end
        if (r < 55)
            put_length_value();
        else if (r < 85)
            put_type_value();
        else
            put_text("1");
        if ($urandom_range(9) == 0) begin
            put_byte(CH_CR);
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(255)));
            put_byte(CH_LF);
        end else begin
            put_crlf();
        end
    endtask

    task automatic send_blk(input int n);
        for (int k = 0; k < n; k++) drive_word(blk[k], 1'b0, 1'b0, '0);
    endtask

    task automatic send_random_block();
        int roll;
        blk.delete();
        roll = $urandom_range(99);
        if (roll < 4) begin
            repeat ($urandom_range(1, 10)) put_byte(8'($urandom_range(255)));
            send_blk(blk.size());
            return;
        end
        repeat ($urandom_range(4)) put_header_line();
        put_crlf();
        if (roll < 13) begin
            send_blk($urandom_range(blk.size() - 1));
            drive_word(8'($urandom_range(255)), 1'b1, 1'b0, '0);
        end else begin
            send_blk(blk.size());
        end
    endtask

    initial begin
        int          phase_start;
        int          blocks;
        int          last;
        string       s;
        clear_block();

        add_row("\015\012", 0, 1, 0, 0, ERR_NONE);
        add_row("", 1, 1, 0, 0, ERR_PARSE);
        add_row("Content-Length: 2147483647\015\012\015\012", 0, 1, 2147483647, 0, ERR_NONE);
        add_row("Content-Length: -2147483648\015\012\015\012", 0, 1, 32'sh8000_0000, 0,
                ERR_NONE);
        add_row("Content-Length: 2147483648\015\012\015\012", 0, 1, 0, 0, ERR_LENGTH);
        add_row("Content-Length: -2147483649\015\012\015\012", 0, 1, 0, 0, ERR_LENGTH);
        add_row("Content-Type: utf-8\015\012Content-Length: 0\015\012\015\012", 0, 1, 0, 1,
                ERR_NONE);
        add_row("Content-Type: utf8\015\012\015\012", 0, 1, 0, 1, ERR_NONE);
        add_row("Content-Type: utf-16\015\012\015\012", 0, 1, 0, 0, ERR_TYPE);
        add_row("Host: x\015\012\015\012", 0, 1, 0, 0, ERR_HEADER);
        add_row("Content-Length 12\015\012\015\012", 0, 1, 0, 0, ERR_PARSE);
        add_row("Content-Length:12\015\012\015\012", 0, 1, 0, 0, ERR_PARSE);
        add_row("Content-Length: 42\015\012Bad\015\012Content-Type: utf8\015\012\015\012",
                0, 1, 42, 0, ERR_PARSE);
        add_row("Content-Length: abc\015\012\015\012", 0, 1, 0, 0, ERR_LENGTH);
        add_row("Content-Length: +\015\012\015\012", 0, 1, 0, 0, ERR_LENGTH);
        add_row("Content-Length: 5\015\012Content-", 1, 1, 0, 0, ERR_PARSE);
        add_row("Content-Length:  \t +0017xyz\015\012\015\012", 0, 0, 0, 0, ERR_NONE);
        add_row("Content-Length: 7\015junk\012\015\012", 0, 0, 0, 0, ERR_NONE);
        add_row("Content-Length: 9\015\012Content-Length: -10\015\012\015\012", 0, 0, 0, 0,
                ERR_NONE);
        add_row("Content-Length-Extra-Long: 1\015\012\015\012", 0, 0, 0, 0, ERR_NONE);
        add_row("Content-Type: utf-8-and-more\015\012\015\012", 0, 0, 0, 0, ERR_NONE);
        add_row("\377\200: \377\015\012\015\012", 0, 0, 0, 0, ERR_NONE);
        add_row(":  \015\012\015\012", 0, 0, 0, 0, ERR_NONE);
        add_row("Content-Length: 99999999999999999999\015\012\015\012", 0, 0, 0, 0, ERR_NONE);
        add_row("\015\015\012", 0, 0, 0, 0, ERR_NONE);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle_pct = 14;
        rcv_idle_pct = 57;
        for (int row = 0; row < row_text.size(); row++) begin
            s    = row_text[row];
            last = s.len() - 1;
            for (int k = 0; k <= last; k++)
                drive_word(s[k], 1'b0, row_typed[row] && !row_end[row] && k == last,
                           row_exp[row]);
            if (row_end[row])
                drive_word(8'($urandom_range(255)), 1'b1, row_typed[row], row_exp[row]);
        end
        wait_results_drained();

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    snd_idle_pct = 14;
                    rcv_idle_pct = 57;
                end
                1: begin
                    snd_idle_pct = 57;
                    rcv_idle_pct = 14;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            phase_start = words_sent;
            blocks      = 0;
            while (words_sent - phase_start < 350 || blocks < 4) begin
                send_random_block();
                blocks++;
            end
            wait_results_drained();
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        for (int n = 0; n < 4000 && header_results_due.size() != 0; n++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (header_results_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", header_results_due.size()));
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #6_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
